// ===== sv/vrp_pkg.sv =====
package vrp_pkg;

	localparam int SCREEN_WIDTH  = 900;
	localparam int SCREEN_HEIGHT = 700;

	localparam int DIV_STEPS = 32;
	localparam int XY_QBITS  = 17;

	localparam logic [15:0] COS_X_RST = 16'sd16384;
	localparam logic [15:0] SIN_X_RST = 16'sd0;
	localparam logic [15:0] COS_Z_RST = 16'sd16384;
	localparam logic [15:0] SIN_Z_RST = 16'sd0;
	localparam logic [15:0] PXS_RST   = 16'd12743;
	localparam logic [15:0] PYS_RST   = 16'd16384;
	localparam logic [15:0] PZS_RST   = 16'd16550;
	localparam logic [31:0] PZO_RST   = 32'hFFF9_AFD7;

	localparam logic signed [19:0] W_OFFSET = 20'sd12288;
	localparam logic signed [32:0] RND_Q14  = 33'sd8192;
	localparam logic signed [39:0] ONE_Q26  = 40'sd67108864;

	typedef enum logic [2:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Z = 3'd2,
		REG_SIN_Z = 3'd3,
		REG_PXS   = 3'd4,
		REG_PYS   = 3'd5,
		REG_PZS   = 3'd6,
		REG_PZO   = 3'd7
	} reg_idx_t;

endpackage

// ===== sv/vertex_rotate_project_core.sv =====
// Vertex rotate/perspective project: one word per clock unless stalled.
// Input channel: in_valid/in_stall with vert_x, vert_y, vert_z (Q4.12).
// Output channel: out_valid/out_stall with screen_x, screen_y (pixels),
// depth (Q20.12) and w_zero (translated z was zero, divisor forced to 1).
// Config: cfg_we writes cfg_data to register cfg_index on a rising edge;
// write only while no words are in flight.
// The pipeline has 8 rotate/project multiply-add stages, 32 restoring
// divider stages (one depth quotient bit per stage; x and y bits only in
// the stages for their low XY_QBITS bits) and one output register.
// One word per clock unless stalled; the divider chain sets the latency.
// Reset clears all valid bits and loads the default rotation (identity)
// and projection registers.
// When out_stall is high with a word waiting, the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
module vertex_rotate_project_core import vrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] vert_x,
	input  logic signed [15:0] vert_y,
	input  logic signed [15:0] vert_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] screen_x,
	output logic signed [15:0] screen_y,
	output logic signed [31:0] depth,
	output logic               w_zero,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic signed [15:0] cos_x_q, sin_x_q, cos_z_q, sin_z_q;
	logic [15:0] pxs_q, pys_q, pzs_q;
	logic signed [31:0] pzo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= COS_X_RST;
			sin_x_q <= SIN_X_RST;
			cos_z_q <= COS_Z_RST;
			sin_z_q <= SIN_Z_RST;
			pxs_q   <= PXS_RST;
			pys_q   <= PYS_RST;
			pzs_q   <= PZS_RST;
			pzo_q   <= PZO_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COS_X: cos_x_q <= cfg_data[15:0];
				REG_SIN_X: sin_x_q <= cfg_data[15:0];
				REG_COS_Z: cos_z_q <= cfg_data[15:0];
				REG_SIN_Z: sin_z_q <= cfg_data[15:0];
				REG_PXS:   pxs_q   <= cfg_data[15:0];
				REG_PYS:   pys_q   <= cfg_data[15:0];
				REG_PZS:   pzs_q   <= cfg_data[15:0];
				REG_PZO:   pzo_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid chain: s1..s8, then divider stages, then output
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_d [1:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int i = 1; i <= DIV_STEPS; i++) v_d[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_d[1] <= v_s8;
			for (int i = 2; i <= DIV_STEPS; i++) v_d[i] <= v_d[i-1];
			out_valid <= v_d[DIV_STEPS];
		end
	end

	// s1: X rotation products
	logic signed [15:0] x_s1;
	logic signed [31:0] ycx_s1, zsx_s1, ysx_s1, zcx_s1;
	// s2: X rotation rounded
	logic signed [15:0] x_s2;
	logic signed [18:0] y1_s2, z1_s2;
	// s3: Z rotation products
	logic signed [31:0] xcz_s3, xsz_s3;
	logic signed [34:0] ysz_s3, ycz_s3;
	logic signed [19:0] w_s3;
	// s4: Z rotation rounded
	logic signed [21:0] x2_s4, y2_s4;
	logic signed [19:0] w_s4;
	// s5: projection products
	logic signed [38:0] px_s5, py_s5;
	logic signed [36:0] pzm_s5;
	logic signed [19:0] w_s5;
	// s6: numerators
	logic signed [39:0] nx_s6, ny_s6;
	logic signed [46:0] pz_s6;
	logic signed [19:0] w_s6;
	logic               wz_s6;
	// s7: screen scale
	logic signed [50:0] mx_s7, my_s7;
	logic signed [46:0] pz_s7;
	logic signed [19:0] w_s7;
	logic               wz_s7;

	logic signed [32:0] y1_sum, z1_sum;
	logic signed [35:0] x2_sum, y2_sum;
	assign y1_sum = 33'(ycx_s1) - 33'(zsx_s1) + RND_Q14;
	assign z1_sum = 33'(ysx_s1) + 33'(zcx_s1) + RND_Q14;
	assign x2_sum = 36'(xcz_s3) - 36'(ysz_s3) + 36'(RND_Q14);
	assign y2_sum = 36'(xsz_s3) + 36'(ycz_s3) + 36'(RND_Q14);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= vert_x;
			ycx_s1 <= 32'(vert_y) * 32'(cos_x_q);
			zsx_s1 <= 32'(vert_z) * 32'(sin_x_q);
			ysx_s1 <= 32'(vert_y) * 32'(sin_x_q);
			zcx_s1 <= 32'(vert_z) * 32'(cos_x_q);

			x_s2  <= x_s1;
			y1_s2 <= y1_sum[32:14];
			z1_s2 <= z1_sum[32:14];

			xcz_s3 <= 32'(x_s2) * 32'(cos_z_q);
			xsz_s3 <= 32'(x_s2) * 32'(sin_z_q);
			ysz_s3 <= 35'(y1_s2) * 35'(sin_z_q);
			ycz_s3 <= 35'(y1_s2) * 35'(cos_z_q);
			w_s3   <= 20'(z1_s2) + W_OFFSET;

			x2_s4 <= x2_sum[35:14];
			y2_s4 <= y2_sum[35:14];
			w_s4  <= w_s3;

			px_s5  <= 39'(x2_s4) * $signed({23'd0, pxs_q});
			py_s5  <= 39'(y2_s4) * $signed({23'd0, pys_q});
			pzm_s5 <= 37'(w_s4) * $signed({21'd0, pzs_q});
			w_s5   <= w_s4;

			wz_s6 <= (w_s5 == '0);
			nx_s6 <= 40'(px_s5) + ((w_s5 == '0) ? ONE_Q26 : (40'(w_s5) <<< 14));
			ny_s6 <= 40'(py_s5) + ((w_s5 == '0) ? ONE_Q26 : (40'(w_s5) <<< 14));
			pz_s6 <= 47'(pzm_s5) + (47'(pzo_q) <<< 14);
			w_s6  <= w_s5;

			mx_s7 <= 51'(nx_s6) * 51'(SCREEN_WIDTH);
			my_s7 <= 51'(ny_s6) * 51'(SCREEN_HEIGHT);
			pz_s7 <= pz_s6;
			w_s7  <= w_s6;
			wz_s7 <= wz_s6;
		end
	end

	// s8: magnitudes, signs, overflow checks
	logic [50:0] mx_mag, my_mag;
	logic [46:0] pz_mag;
	logic [19:0] w_mag;
	logic [35:0] dvx, dvy;
	logic [44:0] dvz;
	logic [19:0] dsr;

	assign mx_mag = mx_s7[50] ? 51'(-mx_s7) : 51'(mx_s7);
	assign my_mag = my_s7[50] ? 51'(-my_s7) : 51'(my_s7);
	assign pz_mag = pz_s7[46] ? 47'(-pz_s7) : 47'(pz_s7);
	assign w_mag  = w_s7[19] ? 20'(-w_s7) : 20'(w_s7);
	assign dvx    = wz_s7 ? 36'(mx_mag >> 27) : 36'(mx_mag >> 15);
	assign dvy    = wz_s7 ? 36'(my_mag >> 27) : 36'(my_mag >> 15);
	assign dvz    = wz_s7 ? 45'(pz_mag >> 14) : 45'(pz_mag >> 2);
	assign dsr    = wz_s7 ? 20'd1 : w_mag;

	logic [35:0] rx_d [0:DIV_STEPS];
	logic [35:0] ry_d [0:DIV_STEPS];
	logic [44:0] rz_d [0:DIV_STEPS];
	logic [XY_QBITS-1:0] qx_d [0:DIV_STEPS];
	logic [XY_QBITS-1:0] qy_d [0:DIV_STEPS];
	logic [31:0] qz_d [0:DIV_STEPS];
	logic [19:0] ds_d [0:DIV_STEPS];
	logic nx_d [0:DIV_STEPS];
	logic ny_d [0:DIV_STEPS];
	logic nz_d [0:DIV_STEPS];
	logic ox_d [0:DIV_STEPS];
	logic oy_d [0:DIV_STEPS];
	logic oz_d [0:DIV_STEPS];
	logic wz_d [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_d[0] <= dvx;
			ry_d[0] <= dvy;
			rz_d[0] <= dvz;
			qx_d[0] <= '0;
			qy_d[0] <= '0;
			qz_d[0] <= '0;
			ds_d[0] <= dsr;
			nx_d[0] <= mx_s7[50] ^ w_s7[19];
			ny_d[0] <= my_s7[50] ^ w_s7[19];
			nz_d[0] <= pz_s7[46] ^ w_s7[19];
			ox_d[0] <= (dvx >> XY_QBITS) >= 36'(dsr);
			oy_d[0] <= (dvy >> XY_QBITS) >= 36'(dsr);
			oz_d[0] <= (dvz >> 32) >= 45'(dsr);
			wz_d[0] <= wz_s7;
		end
	end

	// restoring divide, stage i resolves quotient bit 31-i
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		localparam int K = DIV_STEPS - 1 - i;
		logic [51:0] tz;
		assign tz = {7'd0, rz_d[i]} - (52'(ds_d[i]) << K);

		always_ff @(posedge clk) begin
			if (adv) begin
				ds_d[i+1] <= ds_d[i];
				nx_d[i+1] <= nx_d[i];
				ny_d[i+1] <= ny_d[i];
				nz_d[i+1] <= nz_d[i];
				ox_d[i+1] <= ox_d[i];
				oy_d[i+1] <= oy_d[i];
				oz_d[i+1] <= oz_d[i];
				wz_d[i+1] <= wz_d[i];
				if (!tz[51]) begin
					rz_d[i+1] <= tz[44:0];
					qz_d[i+1] <= qz_d[i] | (32'd1 << K);
				end else begin
					rz_d[i+1] <= rz_d[i];
					qz_d[i+1] <= qz_d[i];
				end
			end
		end

		if (K < XY_QBITS) begin : g_xy
			logic [36:0] tx, ty;
			assign tx = {1'b0, rx_d[i]} - (37'(ds_d[i]) << K);
			assign ty = {1'b0, ry_d[i]} - (37'(ds_d[i]) << K);
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!tx[36]) begin
						rx_d[i+1] <= tx[35:0];
						qx_d[i+1] <= qx_d[i] | (XY_QBITS'(1) << K);
					end else begin
						rx_d[i+1] <= rx_d[i];
						qx_d[i+1] <= qx_d[i];
					end
					if (!ty[36]) begin
						ry_d[i+1] <= ty[35:0];
						qy_d[i+1] <= qy_d[i] | (XY_QBITS'(1) << K);
					end else begin
						ry_d[i+1] <= ry_d[i];
						qy_d[i+1] <= qy_d[i];
					end
				end
			end
		end else begin : g_xy_hold
			always_ff @(posedge clk) begin
				if (adv) begin
					rx_d[i+1] <= rx_d[i];
					ry_d[i+1] <= ry_d[i];
					qx_d[i+1] <= qx_d[i];
					qy_d[i+1] <= qy_d[i];
				end
			end
		end
	end

	// sign and saturate
	logic [XY_QBITS-1:0] qx, qy;
	logic [31:0] qz;
	logic signed [15:0] sx_f, sy_f;
	logic signed [31:0] dz_f;

	assign qx = qx_d[DIV_STEPS];
	assign qy = qy_d[DIV_STEPS];
	assign qz = qz_d[DIV_STEPS];

	always_comb begin
		if (nx_d[DIV_STEPS]) begin
			if (ox_d[DIV_STEPS] || qx > XY_QBITS'(32768)) sx_f = 16'sh8000;
			else sx_f = 16'(-qx);
		end else begin
			if (ox_d[DIV_STEPS] || qx > XY_QBITS'(32767)) sx_f = 16'sh7FFF;
			else sx_f = 16'(qx);
		end
		if (ny_d[DIV_STEPS]) begin
			if (oy_d[DIV_STEPS] || qy > XY_QBITS'(32768)) sy_f = 16'sh8000;
			else sy_f = 16'(-qy);
		end else begin
			if (oy_d[DIV_STEPS] || qy > XY_QBITS'(32767)) sy_f = 16'sh7FFF;
			else sy_f = 16'(qy);
		end
		if (nz_d[DIV_STEPS]) begin
			if (oz_d[DIV_STEPS] || qz > 32'h8000_0000) dz_f = 32'sh8000_0000;
			else dz_f = 32'(-qz);
		end else begin
			if (oz_d[DIV_STEPS] || qz > 32'h7FFF_FFFF) dz_f = 32'sh7FFF_FFFF;
			else dz_f = qz;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x <= sx_f;
			screen_y <= sy_f;
			depth    <= dz_f;
			w_zero   <= wz_d[DIV_STEPS];
		end
	end

endmodule
